>>> rtl/bai_pkg.sv
// Shared types, widths, register map and opcodes for the broadcast address iterator.
// No dependencies; every other file in rtl/ imports this package.
`timescale 1ns / 1ps

package bai_pkg;

  // Defaults for the top-level parameters
  localparam int MAX_DIMS_DEF    = 4;
  localparam int DIM_BITS_DEF    = 16;
  localparam int OFFSET_BITS_DEF = 32;

  // Fixed field widths
  localparam int SHAPE_W    = 64;
  localparam int RANK_W     = 3;
  localparam int START_W    = 32;
  localparam int RES_W      = 32;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_ADDR_W = 6;
  localparam int CFG_IDX_W  = 3;

  // Register indexes (byte address = 8 * index)
  localparam logic [CFG_IDX_W-1:0] REG_OUT_SHAPE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_A_SHAPE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_B_SHAPE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_RANK  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_A_RANK    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_B_RANK    = 3'd5;

  // Input opcodes
  localparam logic OP_SET  = 1'b0;
  localparam logic OP_STEP = 1'b1;

  // Configuration register contents
  typedef struct packed {
    logic [SHAPE_W-1:0] out_shape;
    logic [SHAPE_W-1:0] a_shape;
    logic [SHAPE_W-1:0] b_shape;
    logic [RANK_W-1:0]  out_rank;
    logic [RANK_W-1:0]  a_rank;
    logic [RANK_W-1:0]  b_rank;
  } cfg_t;

  // Adder lane controls for the shared arithmetic unit
  typedef struct packed {
    logic sub0;
    logic sub1;
  } alu_ctl_t;

endpackage

>>> rtl/bai_cfg.sv
// APB-style configuration register file: shapes and ranks.
// Depends on bai_pkg (cfg_t, register indexes, port widths).
`timescale 1ns / 1ps

module bai_cfg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [bai_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [bai_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [bai_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                            pready,
  output bai_pkg::cfg_t                   cfg
);
  import bai_pkg::*;

  cfg_t                 cfg_r;
  logic                 wr_en;
  logic [CFG_IDX_W-1:0] idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = paddr[CFG_ADDR_W-1 -: CFG_IDX_W];
  assign cfg    = cfg_r;

  // Register writes on the access phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.out_shape <= '0;
      cfg_r.a_shape   <= '0;
      cfg_r.b_shape   <= '0;
      cfg_r.out_rank  <= RANK_W'(1);
      cfg_r.a_rank    <= '0;
      cfg_r.b_rank    <= '0;
    end else if (wr_en) begin
      unique case (idx)
        REG_OUT_SHAPE: cfg_r.out_shape <= pwdata[SHAPE_W-1:0];
        REG_A_SHAPE:   cfg_r.a_shape   <= pwdata[SHAPE_W-1:0];
        REG_B_SHAPE:   cfg_r.b_shape   <= pwdata[SHAPE_W-1:0];
        REG_OUT_RANK:  cfg_r.out_rank  <= pwdata[RANK_W-1:0];
        REG_A_RANK:    cfg_r.a_rank    <= pwdata[RANK_W-1:0];
        REG_B_RANK:    cfg_r.b_rank    <= pwdata[RANK_W-1:0];
        default: ;
      endcase
    end
  end

  // Read mux; unmapped addresses read zero
  always_comb begin
    unique case (idx)
      REG_OUT_SHAPE: prdata = CFG_DATA_W'(cfg_r.out_shape);
      REG_A_SHAPE:   prdata = CFG_DATA_W'(cfg_r.a_shape);
      REG_B_SHAPE:   prdata = CFG_DATA_W'(cfg_r.b_shape);
      REG_OUT_RANK:  prdata = CFG_DATA_W'(cfg_r.out_rank);
      REG_A_RANK:    prdata = CFG_DATA_W'(cfg_r.a_rank);
      REG_B_RANK:    prdata = CFG_DATA_W'(cfg_r.b_rank);
      default:       prdata = '0;
    endcase
  end

endmodule

>>> rtl/bai_alu.sv
// Shared arithmetic unit: one offset-by-extent multiplier, two add/subtract
// lanes and one restoring-division step. Depends on bai_pkg (alu_ctl_t).
`timescale 1ns / 1ps

module bai_alu #(
  parameter int OFF_W = bai_pkg::OFFSET_BITS_DEF,
  parameter int DIM_W = bai_pkg::DIM_BITS_DEF
) (
  input  bai_pkg::alu_ctl_t ctl,
  input  logic [OFF_W-1:0]  mul_x,
  input  logic [DIM_W-1:0]  mul_m,
  output logic [OFF_W-1:0]  mul_p,
  input  logic [OFF_W-1:0]  l0_a,
  input  logic [OFF_W-1:0]  l0_b,
  output logic [OFF_W-1:0]  l0_y,
  input  logic [OFF_W-1:0]  l1_a,
  input  logic [OFF_W-1:0]  l1_b,
  output logic [OFF_W-1:0]  l1_y,
  input  logic [DIM_W-1:0]  dv_rem,
  input  logic              dv_bit,
  input  logic [DIM_W-1:0]  dv_d,
  output logic [DIM_W-1:0]  dv_rem_nxt,
  output logic              dv_q
);
  import bai_pkg::*;

  localparam int PW = OFF_W + DIM_W;

  logic [PW-1:0]    mul_full;
  logic [DIM_W:0]   cand;
  logic [DIM_W:0]   diff;

  // Product kept modulo 2^OFF_W
  assign mul_full = PW'(mul_x) * PW'(mul_m);
  assign mul_p    = mul_full[OFF_W-1:0];

  // Offset lanes
  assign l0_y = ctl.sub0 ? (l0_a - l0_b) : (l0_a + l0_b);
  assign l1_y = ctl.sub1 ? (l1_a - l1_b) : (l1_a + l1_b);

  // One quotient bit per call; remainder stays below the divisor
  assign cand       = {dv_rem, dv_bit};
  assign diff       = cand - {1'b0, dv_d};
  assign dv_q       = (cand >= {1'b0, dv_d});
  assign dv_rem_nxt = dv_q ? diff[DIM_W-1:0] : cand[DIM_W-1:0];

endmodule

>>> rtl/bai_seq.sv
// Sequencer and iterator state: stride build, index decomposition and odometer
// step, all on the shared bai_alu. Depends on bai_pkg and bai_alu.
`timescale 1ns / 1ps

module bai_seq #(
  parameter int MAX_DIMS    = bai_pkg::MAX_DIMS_DEF,
  parameter int DIM_BITS    = bai_pkg::DIM_BITS_DEF,
  parameter int OFFSET_BITS = bai_pkg::OFFSET_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  bai_pkg::cfg_t                cfg,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_opcode,
  input  logic [bai_pkg::START_W-1:0]  in_start_index,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [bai_pkg::RES_W-1:0]    out_offset_a,
  output logic [bai_pkg::RES_W-1:0]    out_offset_b
);
  import bai_pkg::*;

  localparam int DI_W  = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int CNT_W = $clog2(START_W);
  localparam int CW    = DIM_BITS + 1;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_STEP = 4'd1;
  localparam logic [3:0] ST_SMUL = 4'd2;
  localparam logic [3:0] ST_SACC = 4'd3;
  localparam logic [3:0] ST_DCHK = 4'd4;
  localparam logic [3:0] ST_DIV  = 4'd5;
  localparam logic [3:0] ST_MULA = 4'd6;
  localparam logic [3:0] ST_ACCA = 4'd7;
  localparam logic [3:0] ST_ACCB = 4'd8;
  localparam logic [3:0] ST_FIN  = 4'd9;

  // Registers
  logic [3:0]             state_r, state_nxt;
  logic [DI_W-1:0]        i_r, i_nxt;
  logic [RANK_W-1:0]      rank_r, rank_nxt;
  logic                   opnd_r, opnd_nxt;
  logic [OFFSET_BITS-1:0] raw_r, raw_nxt;
  logic [OFFSET_BITS-1:0] prod_r, prod_nxt;
  logic [START_W-1:0]     p_r, p_nxt;
  logic [DIM_BITS-1:0]    rem_r, rem_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [DIM_BITS-1:0]    coords_r [MAX_DIMS];
  logic [DIM_BITS-1:0]    coords_nxt [MAX_DIMS];
  logic [OFFSET_BITS-1:0] stride_a_r [MAX_DIMS];
  logic [OFFSET_BITS-1:0] stride_a_nxt [MAX_DIMS];
  logic [OFFSET_BITS-1:0] stride_b_r [MAX_DIMS];
  logic [OFFSET_BITS-1:0] stride_b_nxt [MAX_DIMS];
  logic [OFFSET_BITS-1:0] bs_a_r [MAX_DIMS];
  logic [OFFSET_BITS-1:0] bs_a_nxt [MAX_DIMS];
  logic [OFFSET_BITS-1:0] bs_b_r [MAX_DIMS];
  logic [OFFSET_BITS-1:0] bs_b_nxt [MAX_DIMS];
  logic [OFFSET_BITS-1:0] pos_a_r, pos_a_nxt;
  logic [OFFSET_BITS-1:0] pos_b_r, pos_b_nxt;
  logic [RES_W-1:0]       out_a_r, out_a_nxt;
  logic [RES_W-1:0]       out_b_r, out_b_nxt;
  logic                   out_valid_r, out_valid_nxt;

  // Combinational helpers
  logic [DIM_BITS-1:0]    out_ext [MAX_DIMS];
  logic [DIM_BITS-1:0]    a_fld [MAX_DIMS];
  logic [DIM_BITS-1:0]    b_fld [MAX_DIMS];
  logic [RANK_W-1:0]      r_eff;
  logic [RANK_W-1:0]      opnd_rank;
  logic [RANK_W-1:0]      pad;
  logic [RANK_W-1:0]      fidx;
  logic [DIM_BITS-1:0]    pext;
  logic [DIM_BITS-1:0]    cur_ext;
  logic [CW-1:0]          coord_inc;
  logic                   wrap;
  logic                   last_dim;
  logic                   in_acc;
  logic                   out_xfer;
  logic [OFFSET_BITS-1:0] back_val;

  // Shared unit ports
  alu_ctl_t               alu_ctl;
  logic [OFFSET_BITS-1:0] mul_x, mul_p;
  logic [DIM_BITS-1:0]    mul_m;
  logic [OFFSET_BITS-1:0] l0_a, l0_b, l0_y, l1_a, l1_b, l1_y;
  logic [DIM_BITS-1:0]    dv_rem_nxt;
  logic                   dv_q;

  bai_alu #(
    .OFF_W (OFFSET_BITS),
    .DIM_W (DIM_BITS)
  ) u_alu (
    .ctl        (alu_ctl),
    .mul_x      (mul_x),
    .mul_m      (mul_m),
    .mul_p      (mul_p),
    .l0_a       (l0_a),
    .l0_b       (l0_b),
    .l0_y       (l0_y),
    .l1_a       (l1_a),
    .l1_b       (l1_b),
    .l1_y       (l1_y),
    .dv_rem     (rem_r),
    .dv_bit     (p_r[START_W-1]),
    .dv_d       (cur_ext),
    .dv_rem_nxt (dv_rem_nxt),
    .dv_q       (dv_q)
  );

  assign in_stall     = (state_r != ST_IDLE);
  assign in_acc       = in_valid && !in_stall;
  assign out_xfer     = out_valid_r && !out_stall;
  assign out_valid    = out_valid_r;
  assign out_offset_a = out_a_r;
  assign out_offset_b = out_b_r;

  // Shape fields, dimension 0 in the top field
  always_comb begin
    for (int k = 0; k < MAX_DIMS; k++) begin
      out_ext[k] = cfg.out_shape[(MAX_DIMS-1-k)*DIM_BITS +: DIM_BITS];
      a_fld[k]   = cfg.a_shape[(MAX_DIMS-1-k)*DIM_BITS +: DIM_BITS];
      b_fld[k]   = cfg.b_shape[(MAX_DIMS-1-k)*DIM_BITS +: DIM_BITS];
    end
  end

  // Effective output rank: zero acts as one, clamp to MAX_DIMS
  always_comb begin
    if (cfg.out_rank == '0) begin
      r_eff = RANK_W'(1);
    end else if (cfg.out_rank > RANK_W'(MAX_DIMS)) begin
      r_eff = RANK_W'(MAX_DIMS);
    end else begin
      r_eff = cfg.out_rank;
    end
  end

  // Padded extent of the operand being built, at dimension i_r
  always_comb begin
    opnd_rank = opnd_r ? cfg.b_rank : cfg.a_rank;
    if (opnd_rank > RANK_W'(MAX_DIMS)) begin
      opnd_rank = RANK_W'(MAX_DIMS);
    end
    pad  = '0;
    fidx = RANK_W'(i_r);
    if (opnd_rank < rank_r) begin
      pad  = rank_r - opnd_rank;
      fidx = RANK_W'(i_r) - pad;
    end
    if (RANK_W'(i_r) < pad) begin
      pext = DIM_BITS'(1);
    end else begin
      pext = opnd_r ? b_fld[fidx[DI_W-1:0]] : a_fld[fidx[DI_W-1:0]];
    end
  end

  assign cur_ext   = out_ext[i_r];
  assign coord_inc = CW'(coords_r[i_r]) + CW'(1);
  assign wrap      = (coord_inc == CW'(cur_ext));
  assign last_dim  = (i_r == '0);

  // Operand steering into the shared unit
  always_comb begin
    alu_ctl.sub0 = wrap;
    alu_ctl.sub1 = wrap;
    mul_x        = raw_r;
    mul_m        = pext - DIM_BITS'(1);
    l0_a         = pos_a_r;
    l0_b         = wrap ? bs_a_r[i_r] : stride_a_r[i_r];
    l1_a         = pos_b_r;
    l1_b         = wrap ? bs_b_r[i_r] : stride_b_r[i_r];
    unique case (state_r)
      ST_SACC: begin
        alu_ctl.sub0 = 1'b0;
        alu_ctl.sub1 = 1'b1;
        l0_a         = prod_r;
        l0_b         = raw_r;
        l1_a         = '0;
        l1_b         = raw_r;
      end
      ST_MULA: begin
        mul_x = stride_a_r[i_r];
        mul_m = rem_r;
      end
      ST_ACCA: begin
        alu_ctl.sub0 = 1'b0;
        l0_a         = pos_a_r;
        l0_b         = prod_r;
        mul_x        = stride_b_r[i_r];
        mul_m        = rem_r;
      end
      ST_ACCB: begin
        alu_ctl.sub1 = 1'b0;
        l1_a         = pos_b_r;
        l1_b         = prod_r;
      end
      default: ;
    endcase
  end

  // Back-stride of a zero extent is minus the running product
  assign back_val = (pext == '0) ? l1_y : prod_r;

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    i_nxt         = i_r;
    rank_nxt      = rank_r;
    opnd_nxt      = opnd_r;
    raw_nxt       = raw_r;
    prod_nxt      = prod_r;
    p_nxt         = p_r;
    rem_nxt       = rem_r;
    cnt_nxt       = cnt_r;
    coords_nxt    = coords_r;
    stride_a_nxt  = stride_a_r;
    stride_b_nxt  = stride_b_r;
    bs_a_nxt      = bs_a_r;
    bs_b_nxt      = bs_b_r;
    pos_a_nxt     = pos_a_r;
    pos_b_nxt     = pos_b_r;
    out_a_nxt     = out_a_r;
    out_b_nxt     = out_b_r;
    out_valid_nxt = out_valid_r && !out_xfer;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          rank_nxt = r_eff;
          i_nxt    = DI_W'(r_eff - RANK_W'(1));
          if (in_opcode == OP_STEP) begin
            state_nxt = ST_STEP;
          end else begin
            for (int k = 0; k < MAX_DIMS; k++) begin
              coords_nxt[k]   = '0;
              stride_a_nxt[k] = '0;
              stride_b_nxt[k] = '0;
              bs_a_nxt[k]     = '0;
              bs_b_nxt[k]     = '0;
            end
            pos_a_nxt = '0;
            pos_b_nxt = '0;
            raw_nxt   = OFFSET_BITS'(1);
            opnd_nxt  = 1'b0;
            p_nxt     = in_start_index;
            state_nxt = ST_SMUL;
          end
        end
      end

      // Odometer: one dimension per cycle, stop at the first non-wrapping digit or once dimension 0 wraps
      ST_STEP: begin
        pos_a_nxt = l0_y;
        pos_b_nxt = l1_y;
        if (wrap) begin
          coords_nxt[i_r] = '0;
          if (last_dim) begin
            state_nxt = ST_FIN;
          end else begin
            i_nxt = i_r - DI_W'(1);
          end
        end else begin
          coords_nxt[i_r] = coord_inc[DIM_BITS-1:0];
          state_nxt       = ST_FIN;
        end
      end

      // Stride build: raw * (ext - 1) into the product register
      ST_SMUL: begin
        prod_nxt  = mul_p;
        state_nxt = ST_SACC;
      end

      ST_SACC: begin
        if (opnd_r) begin
          stride_b_nxt[i_r] = (pext == DIM_BITS'(1)) ? '0 : raw_r;
          bs_b_nxt[i_r]     = back_val;
        end else begin
          stride_a_nxt[i_r] = (pext == DIM_BITS'(1)) ? '0 : raw_r;
          bs_a_nxt[i_r]     = back_val;
        end
        raw_nxt = (pext == '0) ? '0 : l0_y;
        if (last_dim) begin
          i_nxt = DI_W'(rank_r - RANK_W'(1));
          if (opnd_r) begin
            state_nxt = ST_DCHK;
          end else begin
            opnd_nxt  = 1'b1;
            raw_nxt   = OFFSET_BITS'(1);
            state_nxt = ST_SMUL;
          end
        end else begin
          i_nxt     = i_r - DI_W'(1);
          state_nxt = ST_SMUL;
        end
      end

      // Decomposition: stop once the index is used up or on a zero extent
      ST_DCHK: begin
        if (p_r == '0 || cur_ext == '0) begin
          state_nxt = ST_FIN;
        end else begin
          rem_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = ST_DIV;
        end
      end

      // One quotient bit per cycle; p_r shifts into the quotient
      ST_DIV: begin
        rem_nxt = dv_rem_nxt;
        p_nxt   = {p_r[START_W-2:0], dv_q};
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(START_W - 1)) begin
          state_nxt = ST_MULA;
        end
      end

      ST_MULA: begin
        coords_nxt[i_r] = rem_r;
        prod_nxt        = mul_p;
        state_nxt       = ST_ACCA;
      end

      ST_ACCA: begin
        pos_a_nxt = l0_y;
        prod_nxt  = mul_p;
        state_nxt = ST_ACCB;
      end

      ST_ACCB: begin
        pos_b_nxt = l1_y;
        if (last_dim) begin
          state_nxt = ST_FIN;
        end else begin
          i_nxt     = i_r - DI_W'(1);
          state_nxt = ST_DCHK;
        end
      end

      // Load the output register once it is free
      ST_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_a_nxt     = RES_W'(pos_a_r);
          out_b_nxt     = RES_W'(pos_b_r);
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // State update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      pos_a_r     <= '0;
      pos_b_r     <= '0;
      for (int k = 0; k < MAX_DIMS; k++) begin
        coords_r[k]   <= '0;
        stride_a_r[k] <= '0;
        stride_b_r[k] <= '0;
        bs_a_r[k]     <= '0;
        bs_b_r[k]     <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      pos_a_r     <= pos_a_nxt;
      pos_b_r     <= pos_b_nxt;
      coords_r    <= coords_nxt;
      stride_a_r  <= stride_a_nxt;
      stride_b_r  <= stride_b_nxt;
      bs_a_r      <= bs_a_nxt;
      bs_b_r      <= bs_b_nxt;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    i_r     <= i_nxt;
    rank_r  <= rank_nxt;
    opnd_r  <= opnd_nxt;
    raw_r   <= raw_nxt;
    prod_r  <= prod_nxt;
    p_r     <= p_nxt;
    rem_r   <= rem_nxt;
    cnt_r   <= cnt_nxt;
    out_a_r <= out_a_nxt;
    out_b_r <= out_b_nxt;
  end

endmodule

>>> rtl/broadcast_address_iterator.sv
// Broadcast address iterator, top level: configuration registers plus sequencer.
// Depends on bai_pkg, bai_cfg, bai_seq (and bai_alu below it).
`timescale 1ns / 1ps

// Walks an output tensor of up to MAX_DIMS dimensions in row-major order and
// gives, per transfer, the flat offsets into two broadcast operands A and B.
// in_opcode = set (0) rebuilds all strides and decomposes in_start_index;
// step (1) advances the coordinate odometer by one element. Every accepted
// item yields exactly one result. Items are handled one at a time on a single
// shared unit (one OFFSET_BITS x DIM_BITS multiplier, two offset adders, one
// division step), and in_stall stays high while an item is in work.
// A step walks the carry through the dimensions it visits (1 .. rank), then
// finishes. A set builds both stride tables (a multiply and an accumulate
// state per dimension per operand), then decomposes in_start_index one
// dimension at a time (a bit-serial division over all 32 index bits and
// a multiply-accumulate into each offset) and finishes; the decomposition
// stops early once the index is used up or at a zero extent.
// The result sits in an output register; a new item is accepted while it
// waits. Configuration is to be written only while the block is idle; the block itself leaves this to the user.
module broadcast_address_iterator #(
  parameter int MAX_DIMS    = bai_pkg::MAX_DIMS_DEF,
  parameter int DIM_BITS    = bai_pkg::DIM_BITS_DEF,
  parameter int OFFSET_BITS = bai_pkg::OFFSET_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_opcode,
  input  logic [bai_pkg::START_W-1:0]     in_start_index,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [bai_pkg::RES_W-1:0]       out_offset_a,
  output logic [bai_pkg::RES_W-1:0]       out_offset_b,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [bai_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [bai_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [bai_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                            pready
);
  import bai_pkg::*;

  cfg_t cfg;

  // Register file
  bai_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Iterator sequencer and state
  bai_seq #(
    .MAX_DIMS    (MAX_DIMS),
    .DIM_BITS    (DIM_BITS),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_seq (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_opcode      (in_opcode),
    .in_start_index (in_start_index),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_offset_a   (out_offset_a),
    .out_offset_b   (out_offset_b)
  );

endmodule

>>> rtl/bai_chk.sv
// Port-level checker for broadcast_address_iterator, bound to the top level.
// Depends on bai_pkg (result width) and the top-level port list.
`timescale 1ns / 1ps

module bai_chk (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [bai_pkg::RES_W-1:0]    out_offset_a,
  input logic [bai_pkg::RES_W-1:0]    out_offset_b
);
  import bai_pkg::*;

  // An accepted item makes the block busy in the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted but block not busy next cycle");

  // A new result appears only as the block finishes its item
  a_result_at_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $fell(in_stall))
    else $error("result raised while block not finishing");

  // Finishing an item always leaves a result waiting
  a_finish_has_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(in_stall) |-> out_valid)
    else $error("item finished without a result");

  // Stalled result stays valid and unchanged
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid)
    else $error("out_valid dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> ($stable(out_offset_a) && $stable(out_offset_b)))
    else $error("result changed while stalled");

endmodule

bind broadcast_address_iterator bai_chk u_bai_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .out_offset_a (out_offset_a),
  .out_offset_b (out_offset_b)
);

>>> tb/bai_offset_checker.sv
// Passive checker for the broadcast address iterator: watches the register port and
// both transfer channels, predicts offset_a/offset_b per item and compares in order.
// Depends on bai_pkg for widths, register indexes and opcodes.
`timescale 1ns / 1ps

module bai_offset_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  logic                           in_opcode,
  input  logic [bai_pkg::START_W-1:0]    in_start_index,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  logic [bai_pkg::RES_W-1:0]      out_offset_a,
  input  logic [bai_pkg::RES_W-1:0]      out_offset_b,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic                           pready,
  input  logic [bai_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [bai_pkg::CFG_DATA_W-1:0] pwdata,
  output int                             pending,
  output int                             mismatches,
  output int                             compared
);
  import bai_pkg::*;

  localparam int NDIM = MAX_DIMS_DEF;
  localparam int DW   = DIM_BITS_DEF;

  typedef logic [NDIM-1:0][RES_W-1:0] stride_vec_t;

  typedef struct packed {
    logic [RES_W-1:0] offset_a;
    logic [RES_W-1:0] offset_b;
  } offsets_t;

  // Shadow of the configuration registers
  logic [SHAPE_W-1:0] out_shape, a_shape, b_shape;
  logic [RANK_W-1:0]  out_rank, a_rank, b_rank;

  // Predicted iterator state
  logic [NDIM-1:0][DW-1:0] coord;
  stride_vec_t             stride_a, stride_b, back_a, back_b;
  logic [RES_W-1:0]        pos_a, pos_b;

  offsets_t offsets_q[$];
  offsets_t want;

  // Field k of a shape register; field 0 is the top one
  function automatic int unsigned extent_of(input logic [SHAPE_W-1:0] shape, input int k);
    return shape[(NDIM - 1 - k) * DW +: DW];
  endfunction

  // Output rank as the block uses it: 0 counts as 1, anything above NDIM as NDIM
  function automatic int rank_in_use(input logic [RANK_W-1:0] rk);
    if (rk == 0) return 1;
    if (rk > NDIM) return NDIM;
    return int'(rk);
  endfunction

  // Operand extent after left-padding with ones up to rank r
  function automatic int unsigned padded_extent(input logic [SHAPE_W-1:0] shape,
                                                input logic [RANK_W-1:0] rank,
                                                input int d, input int r);
    int rk;
    rk = (rank > NDIM) ? NDIM : int'(rank);
    if (rk < r) return (d < r - rk) ? 1 : extent_of(shape, d - (r - rk));
    return extent_of(shape, d);
  endfunction

  // Row-major strides; extent one gives stride zero, back-stride is (ext-1)*span
  task automatic build_strides(input logic [SHAPE_W-1:0] shape, input logic [RANK_W-1:0] rank,
                               input int r, output stride_vec_t fwd, output stride_vec_t back);
    longint unsigned span, ext, prod;
    int i;
    span = 1;
    fwd  = '0;
    back = '0;
    for (i = r - 1; i >= 0; i--) begin
      ext = padded_extent(shape, rank, i, r);
      fwd[i] = (ext == 1) ? '0 : span[RES_W-1:0];
      prod = (ext - 1) * span;
      back[i] = prod[RES_W-1:0];
      span = (span * ext) & 64'h0000_0000_FFFF_FFFF;
    end
  endtask

  // Set position: rebuild strides, clear, then split the flat index per dimension
  task automatic apply_set(input logic [START_W-1:0] start);
    longint unsigned rest, ext, digit, prod_a, prod_b;
    int r, i;
    r = rank_in_use(out_rank);
    build_strides(a_shape, a_rank, r, stride_a, back_a);
    build_strides(b_shape, b_rank, r, stride_b, back_b);
    coord = '0;
    pos_a = '0;
    pos_b = '0;
    rest = start;
    for (i = r - 1; i >= 0 && rest != 0; i--) begin
      ext = extent_of(out_shape, i);
      // zero extent ends the split, its coordinate stays cleared
      if (ext == 0) break;
      digit = rest % ext;
      coord[i] = digit[DW-1:0];
      prod_a = digit * stride_a[i];
      prod_b = digit * stride_b[i];
      pos_a = pos_a + prod_a[RES_W-1:0];
      pos_b = pos_b + prod_b[RES_W-1:0];
      rest = rest / ext;
    end
  endtask

  // Step: odometer increment from the last dimension, back-strides on wrap
  task automatic apply_step();
    int unsigned ext;
    int r, i;
    r = rank_in_use(out_rank);
    for (i = r - 1; i >= 0; i--) begin
      ext = extent_of(out_shape, i);
      if (coord[i] + 1 == ext) begin
        coord[i] = '0;
        pos_a = pos_a - back_a[i];
        pos_b = pos_b - back_b[i];
      end else begin
        coord[i] = coord[i] + 1'b1;
        pos_a = pos_a + stride_a[i];
        pos_b = pos_b + stride_b[i];
        break;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_shape = '0;
      a_shape   = '0;
      b_shape   = '0;
      out_rank  = 3'd1;
      a_rank    = '0;
      b_rank    = '0;
      coord     = '0;
      stride_a  = '0;
      stride_b  = '0;
      back_a    = '0;
      back_b    = '0;
      pos_a     = '0;
      pos_b     = '0;
      offsets_q.delete();
      mismatches = 0;
      compared   = 0;
      pending   <= 0;
    end else begin
      // register write
      if (psel && penable && pwrite && pready) begin
        case (paddr[CFG_ADDR_W-1:3])
          REG_OUT_SHAPE: out_shape = pwdata[SHAPE_W-1:0];
          REG_A_SHAPE:   a_shape   = pwdata[SHAPE_W-1:0];
          REG_B_SHAPE:   b_shape   = pwdata[SHAPE_W-1:0];
          REG_OUT_RANK:  out_rank  = pwdata[RANK_W-1:0];
          REG_A_RANK:    a_rank    = pwdata[RANK_W-1:0];
          REG_B_RANK:    b_rank    = pwdata[RANK_W-1:0];
          default: ;
        endcase
      end

      // result transfer against the oldest prediction
      if (out_valid && !out_stall) begin
        if (offsets_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result with nothing outstanding: a=%h b=%h",
                     $time, out_offset_a, out_offset_b);
        end else begin
          want = offsets_q.pop_front();
          compared++;
          if (out_offset_a !== want.offset_a || out_offset_b !== want.offset_b) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: offset mismatch: offset_a exp %h got %h, offset_b exp %h got %h",
                       $time, want.offset_a, out_offset_a, want.offset_b, out_offset_b);
          end
        end
      end

      // input transfer: advance the prediction
      if (in_valid && !in_stall) begin
        if (in_opcode == OP_SET) apply_set(in_start_index);
        else apply_step();
        offsets_q.insert(offsets_q.size(), {pos_a, pos_b});
      end

      pending <= offsets_q.size();
    end
  end

endmodule

>>> tb/broadcast_address_iterator_tb.sv
// Testbench top for the broadcast address iterator: clock, reset, register writes,
// input and result traffic with random idling; verdict from bai_offset_checker.
// Depends on bai_pkg, broadcast_address_iterator and tb/bai_offset_checker.sv.
`timescale 1ns / 1ps

module broadcast_address_iterator_tb;
  import bai_pkg::*;

  localparam int NDIM        = MAX_DIMS_DEF;
  localparam int DW          = DIM_BITS_DEF;
  localparam int TOTAL_ITEMS = 1850;
  localparam int PARK_CYCLES = 300;
  localparam int QUIET_LIMIT = 3000;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  in_opcode = OP_STEP;
  logic [START_W-1:0]    in_start_index = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [RES_W-1:0]      out_offset_a, out_offset_b;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  int pending, mismatches, compared;

  // Stimulus knobs and bookkeeping
  logic            calm = 1'b0;
  int              park_total = 0;
  longint unsigned elem_count = 0;
  int              n_set = 0, n_step = 0, n_settings = 0;
  int              quiet_cycles = 0;

  broadcast_address_iterator dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_opcode      (in_opcode),
    .in_start_index (in_start_index),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_offset_a   (out_offset_a),
    .out_offset_b   (out_offset_b),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  bai_offset_checker offset_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_opcode      (in_opcode),
    .in_start_index (in_start_index),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_offset_a   (out_offset_a),
    .out_offset_b   (out_offset_b),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .pready         (pready),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .pending        (pending),
    .mismatches     (mismatches),
    .compared       (compared)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Result side: per-transfer random stall, plus long parking on request
  int stall_left, park_done, park_left;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
      park_done  = 0;
      park_left  = 0;
    end else if (park_total != park_done) begin
      park_done++;
      park_left = PARK_CYCLES;
      out_stall <= 1'b1;
    end else if (park_left != 0) begin
      park_left--;
      out_stall <= 1'b1;
    end else begin
      if (out_valid && !out_stall) stall_left = calm ? 0 : $urandom_range(0, 4);
      if (stall_left != 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog: cycles with no transfer on any port
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("broadcast_address_iterator test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // One input transfer, after a random gap
  task automatic send_item(input logic op, input logic [START_W-1:0] start);
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_opcode      <= op;
    in_start_index <= start;
    do @(posedge clk); while (in_stall);
    if (op == OP_SET) n_set++;
    else n_step++;
  endtask

  // Stop offering and wait for every outstanding result
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Setup and access cycle; the write lands at the edge with pready high
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Full register set, written once the block is idle
  task automatic apply_settings(input logic [SHAPE_W-1:0] os, input logic [SHAPE_W-1:0] as,
                                input logic [SHAPE_W-1:0] bs, input logic [RANK_W-1:0] orank,
                                input logic [RANK_W-1:0] arank, input logic [RANK_W-1:0] brank);
    int r, d;
    drain();
    write_reg(REG_OUT_SHAPE, os);
    write_reg(REG_A_SHAPE, as);
    write_reg(REG_B_SHAPE, bs);
    write_reg(REG_OUT_RANK, CFG_DATA_W'(orank));
    write_reg(REG_A_RANK, CFG_DATA_W'(arank));
    write_reg(REG_B_RANK, CFG_DATA_W'(brank));
    r = (orank == 0) ? 1 : ((orank > NDIM) ? NDIM : int'(orank));
    elem_count = 1;
    for (d = 0; d < r; d++) elem_count = elem_count * os[(NDIM - 1 - d) * DW +: DW];
    n_settings++;
  endtask

  // Mostly small extents so the odometer wraps; a few zeros and large ones
  function automatic logic [DW-1:0] rand_extent();
    int unsigned v;
    v = $urandom_range(0, 23);
    if (v == 0) return '0;
    if (v == 1) return '1;
    if (v == 2) return DW'($urandom_range(7, 16'hFFFE));
    if (v <= 6) return 16'd1;
    return DW'($urandom_range(2, 5));
  endfunction

  // Ranks 0..7, weighted toward 2..4
  function automatic logic [RANK_W-1:0] rand_rank();
    int unsigned v;
    v = $urandom_range(0, 11);
    return (v > 7) ? RANK_W'($urandom_range(2, 4)) : RANK_W'(v);
  endfunction

  // Operand shape, usually broadcast-compatible with the output; unused fields hold junk
  function automatic logic [SHAPE_W-1:0] operand_shape(input logic [SHAPE_W-1:0] os, input int r,
                                                       input logic [RANK_W-1:0] rank);
    logic [SHAPE_W-1:0] s;
    int ra, k, d;
    ra = (rank > NDIM) ? NDIM : int'(rank);
    s = {$urandom, $urandom};
    for (k = 0; k < ra; k++) begin
      d = r - ra + k;
      if (d >= 0 && $urandom_range(0, 4) != 0)
        s[(NDIM - 1 - k) * DW +: DW] = $urandom_range(0, 1) ? os[(NDIM - 1 - d) * DW +: DW]
                                                            : 16'd1;
      else
        s[(NDIM - 1 - k) * DW +: DW] = rand_extent();
    end
    return s;
  endfunction

  // Start index: small, inside the tensor, or anywhere in 32 bits
  function automatic logic [START_W-1:0] pick_start();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 3);
      1: return $urandom;
      default: begin
        if (elem_count == 0 || elem_count > 64'h0000_0000_FFFF_FFFF) return $urandom;
        return $urandom_range(0, int'(elem_count - 1));
      end
    endcase
  endfunction

  initial begin
    logic [SHAPE_W-1:0] os;
    logic [RANK_W-1:0]  orank;
    int                 r, phase, burst, k;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset registers: rank one, extent zero, operands all padding
    send_item(OP_STEP, '0);
    send_item(OP_SET, '1);
    send_item(OP_STEP, 32'h5A5A_A5A5);

    // 2x3x4x5 output, A padded from rank 2, B with unit dimensions; last element then wrap
    apply_settings({16'd2, 16'd3, 16'd4, 16'd5}, {16'd4, 16'd5, 32'd0},
                   {16'd2, 16'd1, 16'd4, 16'd1}, 3'd4, 3'd2, 3'd4);
    send_item(OP_SET, '0);
    send_item(OP_STEP, '0);
    send_item(OP_STEP, '1);
    send_item(OP_STEP, '0);
    send_item(OP_SET, 32'd119);
    send_item(OP_STEP, '0);
    send_item(OP_SET, '1);
    send_item(OP_STEP, '0);

    // new extents and out-of-range rank without a set: steps keep the old strides
    drain();
    write_reg(REG_OUT_SHAPE, {16'd1, 16'd1, 16'd2, 16'hFFFF});
    write_reg(REG_OUT_RANK, 64'd7);
    send_item(OP_STEP, '0);
    send_item(OP_STEP, '0);
    send_item(OP_SET, 32'h8000_0001);
    send_item(OP_STEP, '0);

    // rank zero output, operand ranks above output and above the maximum
    apply_settings({16'hFFFF, 48'h1234_5678_9ABC}, '1, '0, 3'd0, 3'd7, 3'd5);
    send_item(OP_SET, 32'd65534);
    send_item(OP_STEP, '0);
    send_item(OP_STEP, '0);

    // zero extent in the middle of the output shape
    apply_settings({16'd3, 16'd0, 16'd2, 16'd2}, {16'd1, 16'd0, 16'd7, 16'd0},
                   {16'd2, 48'd0}, 3'd4, 3'd3, 3'd1);
    send_item(OP_SET, 32'd100);
    send_item(OP_STEP, '0);
    send_item(OP_STEP, '0);
    send_item(OP_SET, '0);

    // all output and B extents at maximum
    apply_settings('1, {16'd1, 16'hFFFF, 16'd1, 16'd3}, '1, 3'd4, 3'd4, 3'd6);
    send_item(OP_SET, '1);
    send_item(OP_STEP, '0);

    // random phases: new settings, usually a set, then mostly step runs
    phase = 0;
    while (n_set + n_step < TOTAL_ITEMS) begin
      calm <= (phase % 4 == 3);
      orank = rand_rank();
      r = (orank == 0) ? 1 : ((orank > NDIM) ? NDIM : int'(orank));
      os = ($urandom_range(0, 9) == 0) ? {$urandom, $urandom}
                                       : {rand_extent(), rand_extent(), rand_extent(), rand_extent()};
      begin
        logic [RANK_W-1:0] arank, brank;
        arank = rand_rank();
        brank = rand_rank();
        apply_settings(os, operand_shape(os, r, arank), operand_shape(os, r, brank),
                       orank, arank, brank);
      end
      if ($urandom_range(0, 7) != 0) send_item(OP_SET, pick_start());
      burst = $urandom_range(40, 90);
      for (k = 0; k < burst; k++) begin
        // long receiver hold while items keep coming
        if (phase == 2 && k == 10) park_total <= park_total + 1;
        // sender waits for the pipeline to empty
        if (phase == 5 && k == 30) drain();
        if ($urandom_range(0, 15) == 0) send_item(OP_SET, pick_start());
        else send_item(OP_STEP, $urandom);
      end
      phase++;
    end

    drain();
    repeat (100) @(posedge clk);
    $display("Run summary: %0d set and %0d step transfers over %0d register settings",
             n_set, n_step, n_settings);
    $display("Run summary: %0d results compared, %0d mismatches", compared, mismatches);
    if (mismatches == 0 && pending == 0)
      $display("broadcast_address_iterator test passed");
    else
      $display("broadcast_address_iterator test failed");
    $finish;
  end

endmodule
